// ===== rtl/core/tcw_pkg.sv =====
// tcw_pkg: shared constants and types for the text console writer
// no dependencies; imported by text_console_writer_unit
package tcw_pkg;

  // fixed field widths of the command and result ports
  localparam int CHAR_W   = 8;
  localparam int COLOUR_W = 8;
  localparam int CELL_W   = CHAR_W + COLOUR_W;
  localparam int ROWF_W   = 5;
  localparam int COLF_W   = 7;

  // default grid size
  localparam int DEF_COLS = 80;
  localparam int DEF_ROWS = 25;

  // command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // character codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

  // reset colour and reset cell content
  localparam logic [COLOUR_W-1:0] RESET_COLOUR = 8'h07;
  localparam logic [CELL_W-1:0]   RESET_CELL   = {RESET_COLOUR, SPACE_CODE};

  // sequencer states
  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_CLEAR  = 5'b10000
  } tcw_state_e;

endpackage

// ===== rtl/core/text_console_writer_unit.sv =====
// text_console_writer_unit: text-mode console with cell memory and cursor
// depends on tcw_pkg (widths, codes, state type)
//
// channel | direction | handshake              | payload
// --------+-----------+------------------------+---------------------------------------
// command | in        | start, busy            | command_i, char_code_i, read_row_i,
//         |           |                        | read_col_i
// result  | out       | done_o (one-cycle)     | cell_value_o, cursor_row_o, cursor_col_o
// colour  | in        | text_colour_we_i       | text_colour_i
//
// a command transfer happens at a clock edge with start high and busy low
// put: result strobed in the next cycle, busy stays low
// read: one memory read with registered data, busy high for one cycle
// put that runs past the last row: rows are copied up one row through the single
//   read port and single write port of the cell memory, then the bottom row is blanked
// after reset a clearing pass writes grey spaces to all ROWS*COLS cells with busy
//   high; colour writes are taken at any time
// results cannot be stalled: done_o is high for exactly one cycle per command
module text_console_writer_unit #(
  parameter int COLS = tcw_pkg::DEF_COLS,
  parameter int ROWS = tcw_pkg::DEF_ROWS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          command_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::ROWF_W-1:0]    read_row_i,
  input  logic [tcw_pkg::COLF_W-1:0]    read_col_i,
  // colour register
  input  logic                          text_colour_we_i,
  input  logic [tcw_pkg::COLOUR_W-1:0]  text_colour_i,
  // result channel
  output logic                          done_o,
  output logic [tcw_pkg::CELL_W-1:0]    cell_value_o,
  output logic [tcw_pkg::ROWF_W-1:0]    cursor_row_o,
  output logic [tcw_pkg::COLF_W-1:0]    cursor_col_o
);
  import tcw_pkg::*;

  localparam int NCELLS  = ROWS * COLS;
  localparam int ADDR_W  = $clog2(NCELLS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLS);

  localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(NCELLS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_BASE  = ADDR_W'(NCELLS - COLS);
  localparam logic [ADDR_W-1:0] COPY_LAST    = ADDR_W'(NCELLS - COLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(COLS);
  localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLS - 1);

  // cell memory, one write and one registered read per cycle
  logic [CELL_W-1:0] mem_q [NCELLS];
  logic [CELL_W-1:0] rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // control and cursor state
  tcw_state_e          state_q, state_d;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic [ADDR_W-1:0]   pend_addr_q, pend_addr_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic                done_q, done_d;
  logic [CELL_W-1:0]   cell_q, cell_d;
  logic                rd_ok_q, rd_ok_d;
  logic [COLOUR_W-1:0] colour_q;

  // read lookup from the command ports
  logic [31:0]         rd_lin;
  logic                rd_ok;
  logic [ADDR_W-1:0]   rd_addr;
  logic                next_row;

  assign rd_ok   = (32'(read_row_i) < 32'(ROWS)) && (32'(read_col_i) < 32'(COLS));
  assign rd_lin  = 32'(read_row_i) * 32'(COLS) + 32'(read_col_i);
  assign rd_addr = rd_ok ? rd_lin[ADDR_W-1:0] : '0;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    row_d       = row_q;
    col_d       = col_q;
    base_d      = base_q;
    done_d      = 1'b0;
    cell_d      = cell_q;
    rd_ok_d     = rd_ok_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    next_row    = 1'b0;

    case (state_q)
      ST_INIT: begin
        // clearing pass after reset
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = RESET_CELL;
        if (cnt_q == LAST_ADDR) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        mem_raddr = rd_addr;
        if (start) begin
          if (command_i == CMD_READ) begin
            rd_ok_d = rd_ok;
            state_d = ST_READ;
          end else begin
            if (char_code_i == NEWLINE_CODE) begin
              next_row = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = base_q + ADDR_W'(col_q);
              mem_wdata = {colour_q, char_code_i};
              if (col_q == LAST_COL) begin
                next_row = 1'b1;
              end else begin
                col_d = col_q + 1'b1;
              end
            end

            if (next_row) begin
              col_d = '0;
              if (row_q == LAST_ROW) begin
                // cursor already sits on the bottom row; shift the screen up
                state_d = ST_SCROLL;
                cnt_d   = '0;
              end else begin
                row_d  = row_q + 1'b1;
                base_d = base_q + ROW_STRIDE;
                done_d = 1'b1;
                cell_d = '0;
              end
            end else begin
              done_d = 1'b1;
              cell_d = '0;
            end
          end
        end
      end

      ST_READ: begin
        done_d  = 1'b1;
        cell_d  = rd_ok_q ? rdata_q : '0;
        state_d = ST_IDLE;
      end

      ST_SCROLL: begin
        // read one row ahead, write the previous read back one row up
        mem_raddr   = cnt_q + ROW_STRIDE;
        pend_d      = 1'b1;
        pend_addr_d = cnt_q;
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_q;
          mem_wdata = rdata_q;
        end
        if (cnt_q == COPY_LAST) begin
          state_d = ST_CLEAR;
          cnt_d   = BOTTOM_BASE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_CLEAR: begin
        // last copy write first, then blank the bottom row
        mem_we = 1'b1;
        if (pend_q) begin
          mem_waddr = pend_addr_q;
          mem_wdata = rdata_q;
        end else begin
          mem_waddr = cnt_q;
          mem_wdata = {colour_q, SPACE_CODE};
          if (cnt_q == LAST_ADDR) begin
            state_d = ST_IDLE;
            cnt_d   = '0;
            done_d  = 1'b1;
            cell_d  = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // cell memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      row_q    <= '0;
      col_q    <= '0;
      base_q   <= '0;
      done_q   <= 1'b0;
      colour_q <= RESET_COLOUR;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      row_q   <= row_d;
      col_q   <= col_d;
      base_q  <= base_d;
      done_q  <= done_d;
      if (text_colour_we_i) begin
        colour_q <= text_colour_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    cell_q      <= cell_d;
    rd_ok_q     <= rd_ok_d;
  end

  logic [31:0] row_ext;
  logic [31:0] col_ext;

  assign row_ext      = 32'(row_q);
  assign col_ext      = 32'(col_q);
  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign cell_value_o = cell_q;
  assign cursor_row_o = row_ext[ROWF_W-1:0];
  assign cursor_col_o = col_ext[COLF_W-1:0];

  // a result is only strobed once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  // cursor stays inside the grid
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < 32'(ROWS)) && (32'(col_q) < 32'(COLS)))
    else $error("cursor outside grid");

  // row base address tracks the cursor row
  a_base_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(base_q) == 32'(row_q) * 32'(COLS))
    else $error("row base out of step with cursor row");

  // scroll only runs with the cursor parked at the start of the bottom row
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL || state_q == ST_CLEAR) |-> (row_q == LAST_ROW && col_q == '0))
    else $error("scroll with cursor off bottom row");

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for the text console writer, predicts every result
// and compares it field by field; depends on tcw_pkg and text_console_writer_unit
`timescale 1ns / 100ps

module testbench;
  import tcw_pkg::*;

  localparam int COLS = DEF_COLS;
  localparam int ROWS = DEF_ROWS;
  localparam int CELLS = ROWS * COLS;
  // a scroll or the clearing pass after reset keeps both channels quiet while it walks
  // the cell memory, so the watchdog limit is a multiple of the cell count
  localparam int WATCHDOG_LIMIT = 10 * CELLS;
  // after the last result and an idle block, keep watching for stray results
  localparam int DRAIN_CYCLES = CELLS + 16;

  // one result of the console: read cell plus the cursor after the command
  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [ROWF_W-1:0] row;
    logic [COLF_W-1:0] col;
  } console_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic command_i;
  logic [CHAR_W-1:0] char_code_i;
  logic [ROWF_W-1:0] read_row_i;
  logic [COLF_W-1:0] read_col_i;
  logic text_colour_we_i;
  logic [COLOUR_W-1:0] text_colour_i;
  logic done_o;
  logic [CELL_W-1:0] cell_value_o;
  logic [ROWF_W-1:0] cursor_row_o;
  logic [COLF_W-1:0] cursor_col_o;

  // shadow copy of the console: screen, cursor and colour
  logic [CELL_W-1:0] screen_q [CELLS];
  logic [ROWF_W-1:0] cur_row_q;
  logic [COLF_W-1:0] cur_col_q;
  logic [COLOUR_W-1:0] colour_q;

  // results still owed by the block, oldest first
  console_result_t pending_results_q [$];

  int error_count = 0;
  int put_count = 0;
  int newline_count = 0;
  int read_count = 0;
  int scroll_count = 0;
  int colour_write_count = 0;
  int result_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 10;

  always #2 clk_i = ~clk_i;

  text_console_writer_unit #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .char_code_i     (char_code_i),
    .read_row_i      (read_row_i),
    .read_col_i      (read_col_i),
    .text_colour_we_i(text_colour_we_i),
    .text_colour_i   (text_colour_i),
    .done_o          (done_o),
    .cell_value_o    (cell_value_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_col_o    (cursor_col_o)
  );

  // ---------------------------------------------------------------------------
  // console predictor
  // ---------------------------------------------------------------------------

  // cursor to column 0 of the next row; past the last row the screen moves up
  // one row and the bottom row is blanked in the current colour
  function automatic void advance_row();
    cur_col_q = '0;
    if (cur_row_q == ROWS - 1) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_q[i] = screen_q[i + COLS];
      for (int c = 0; c < COLS; c++) screen_q[CELLS - COLS + c] = {colour_q, SPACE_CODE};
      scroll_count++;
    end else begin
      cur_row_q = cur_row_q + 1'b1;
    end
  endfunction

  function automatic console_result_t predict_console(input logic cmd,
      input logic [CHAR_W-1:0] ch, input logic [ROWF_W-1:0] rr,
      input logic [COLF_W-1:0] rc);
    console_result_t res;
    res.cell_val = '0;
    if (cmd == CMD_READ) begin
      // reads outside the grid give zero and touch nothing
      if (rr < ROWS && rc < COLS) res.cell_val = screen_q[rr * COLS + rc];
    end else if (ch == NEWLINE_CODE) begin
      advance_row();
    end else begin
      // every other byte, control codes too, lands in the cell as it is
      screen_q[cur_row_q * COLS + cur_col_q] = {colour_q, ch};
      if (cur_col_q == COLS - 1) advance_row();
      else cur_col_q = cur_col_q + 1'b1;
    end
    res.row = cur_row_q;
    res.col = cur_col_q;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: colour writes, result checks and command transfers, all sampled
  // at the rising edge before any of that edge's updates land
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    console_result_t exp_res;
    if (rst_ni) begin
      if (text_colour_we_i) begin
        colour_q = text_colour_i;
        colour_write_count++;
      end
      // a result transfer is checked against the oldest outstanding prediction
      if (done_o) begin
        result_count++;
        if (pending_results_q.size() == 0) begin
          $display("%0t: unexpected result, actual cell %h row %0d col %0d", $time,
                   cell_value_o, cursor_row_o, cursor_col_o);
          error_count++;
        end else begin
          exp_res = pending_results_q.pop_front();
          if (cell_value_o !== exp_res.cell_val) begin
            $display("%0t: cell_value mismatch, expected %h actual %h", $time,
                     exp_res.cell_val, cell_value_o);
            error_count++;
          end
          if (cursor_row_o !== exp_res.row) begin
            $display("%0t: cursor_row mismatch, expected %0d actual %0d", $time,
                     exp_res.row, cursor_row_o);
            error_count++;
          end
          if (cursor_col_o !== exp_res.col) begin
            $display("%0t: cursor_col mismatch, expected %0d actual %0d", $time,
                     exp_res.col, cursor_col_o);
            error_count++;
          end
        end
      end
      // a command transfer: predict its result right away
      if (start && !busy) begin
        if (command_i == CMD_READ) read_count++;
        else if (char_code_i == NEWLINE_CODE) newline_count++;
        else put_count++;
        pending_results_q.push_back(predict_console(command_i, char_code_i, read_row_i,
                                                    read_col_i));
      end
    end
  end

  // watchdog: counts edges with neither a command nor a result transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, pending_results_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // present one command and hold it until the block takes it; start stays high
  // into the next command unless a random gap is inserted
  task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch,
      input logic [ROWF_W-1:0] rr, input logic [COLF_W-1:0] rc);
    start <= 1'b1;
    command_i <= cmd;
    char_code_i <= ch;
    read_row_i <= rr;
    read_col_i <= rc;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // put: the read address fields are don't-care, so they carry noise
  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_item(CMD_PUT, ch, ROWF_W'($urandom_range(0, 31)), COLF_W'($urandom_range(0, 127)));
  endtask

  // read: the character field is don't-care
  task automatic read_cell(input int r, input int c);
    send_item(CMD_READ, CHAR_W'($urandom_range(0, 255)), ROWF_W'(r), COLF_W'(c));
  endtask

  // wait until every result has come and the block is no longer working
  task automatic settle_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results_q.size() != 0 || busy);
  endtask

  // colour register write, only ever issued from an idle block
  task automatic write_colour(input logic [COLOUR_W-1:0] value);
    settle_idle();
    text_colour_we_i <= 1'b1;
    text_colour_i <= value;
    @(posedge clk_i);
    text_colour_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // screen after the clearing pass: grey spaces, zero outside the grid
  task automatic test_reset_contents();
    read_cell(0, 0);
    read_cell(ROWS - 1, COLS - 1);
    read_cell(12, 40);
    read_cell(ROWS, 0);
    read_cell(0, COLS);
    read_cell(31, 127);
  endtask

  // character extremes and control bytes in extreme and other colours, then a newline and reads
  task automatic test_chars_and_colours();
    write_colour(8'h00);
    put_char(8'h00);
    write_colour(8'hFF);
    put_char(8'hFF);
    put_char(8'h0D);
    put_char(8'h7F);
    write_colour(8'h5A);
    put_char(8'h80);
    put_char(NEWLINE_CODE);
    read_cell(0, 0);
    read_cell(0, 1);
    read_cell(0, 2);
    read_cell(0, 4);
    read_cell(1, 0);
  endtask

  // a full row of random bytes makes the cursor wrap from the last column
  task automatic test_line_wrap();
    write_colour(COLOUR_W'($urandom_range(0, 255)));
    repeat (COLS) put_char(CHAR_W'($urandom_range(11, 255)));
    read_cell(1, COLS - 1);
    read_cell(2, 0);
  endtask

  // reach the bottom row, scroll once by wrapping and once by a newline
  task automatic test_scroll();
    int steps;
    settle_idle();
    steps = ROWS - 1 - cur_row_q;
    repeat (steps) put_char(NEWLINE_CODE);
    write_colour(8'h1E);
    repeat (COLS) put_char(CHAR_W'($urandom_range(11, 255)));
    read_cell(ROWS - 1, 0);
    read_cell(ROWS - 2, COLS - 1);
    write_colour(8'hC3);
    put_char(8'h41);
    put_char(NEWLINE_CODE);
    read_cell(ROWS - 1, COLS - 1);
    read_cell(ROWS - 2, 0);
    read_cell(ROWS - 3, 7);
    read_cell(0, 0);
  endtask

  // mixed traffic in phases of a hundred commands, a new colour each phase;
  // two phases run with no gaps at all
  task automatic test_random_traffic(input int n_items);
    int sent;
    int phase;
    int pick;
    logic [COLOUR_W-1:0] colour;
    sent = 0;
    phase = 0;
    while (sent < n_items) begin
      if (phase == 1) colour = 8'h00;
      else if (phase == 4) colour = 8'hFF;
      else colour = COLOUR_W'($urandom_range(0, 255));
      write_colour(colour);
      send_idle_pct = (phase == 2 || phase == 3) ? 0 : 10;
      for (int i = 0; i < 100 && sent < n_items; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          // mostly reads inside the grid, some anywhere the fields reach
          if ($urandom_range(0, 9) == 0)
            read_cell($urandom_range(0, 31), $urandom_range(0, 127));
          else
            read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
        end else if (pick < 42) begin
          put_char(NEWLINE_CODE);
        end else begin
          put_char(CHAR_W'($urandom_range(0, 255)));
        end
        sent++;
      end
      phase++;
    end
    send_idle_pct = 10;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < CELLS; i++) screen_q[i] = RESET_CELL;
    cur_row_q = '0;
    cur_col_q = '0;
    colour_q = RESET_COLOUR;

    rst_ni <= 1'b0;
    start <= 1'b0;
    command_i <= CMD_PUT;
    char_code_i <= '0;
    read_row_i <= '0;
    read_col_i <= '0;
    text_colour_we_i <= 1'b0;
    text_colour_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_contents();
    test_chars_and_colours();
    test_line_wrap();
    test_scroll();
    test_random_traffic(800);

    // drain: everything answered and the block idle, then keep watching for stray results
    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d character puts, %0d newlines, %0d cell reads, %0d scrolls",
             put_count, newline_count, read_count, scroll_count);
    $display("%0d colour writes, %0d results compared, %0d mismatches",
             colour_write_count, result_count, error_count);
    if (error_count == 0 && pending_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tcw_pkg.sv
rtl/core/text_console_writer_unit.sv
dv/testbench.sv
